// ===== hdl/cpseg_pkg.sv =====
package cpseg_pkg;

	// how the result was found
	typedef enum logic [1:0] {
		WHERE_PROJ  = 2'd0,
		WHERE_END   = 2'd1,
		WHERE_START = 2'd2,
		WHERE_DEGEN = 2'd3
	} where_t;

endpackage

// ===== hdl/cpseg_div_cell.sv =====
module cpseg_div_cell #(
	parameter int NW    = 52,
	parameter int DW    = 35,
	parameter int QB    = 18,
	parameter int SIDE  = 38,
	parameter int SHIFT = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_i,
	input  logic [NW-1:0]   rx_i,
	input  logic [NW-1:0]   ry_i,
	input  logic [QB-1:0]   qx_i,
	input  logic [QB-1:0]   qy_i,
	input  logic [DW-1:0]   d_i,
	input  logic [SIDE-1:0] side_i,
	output logic            v_o,
	output logic [NW-1:0]   rx_o,
	output logic [NW-1:0]   ry_o,
	output logic [QB-1:0]   qx_o,
	output logic [QB-1:0]   qy_o,
	output logic [DW-1:0]   d_o,
	output logic [SIDE-1:0] side_o
);

	logic [NW-1:0] dsh;
	logic          gex, gey;
	logic          v_q;
	logic [NW-1:0] rx_q, ry_q;
	logic [QB-1:0] qx_q, qy_q;
	logic [DW-1:0] d_q;
	logic [SIDE-1:0] side_q;

	// divisor lined up with this quotient bit
	assign dsh = NW'(d_i) << SHIFT;
	assign gex = rx_i >= dsh;
	assign gey = ry_i >= dsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_q   <= gex ? rx_i - dsh : rx_i;
			ry_q   <= gey ? ry_i - dsh : ry_i;
			qx_q   <= qx_i | (QB'(gex) << SHIFT);
			qy_q   <= qy_i | (QB'(gey) << SHIFT);
			d_q    <= d_i;
			side_q <= side_i;
		end
	end

	assign v_o    = v_q;
	assign rx_o   = rx_q;
	assign ry_o   = ry_q;
	assign qx_o   = qx_q;
	assign qy_o   = qy_q;
	assign d_o    = d_q;
	assign side_o = side_q;

endmodule

// ===== hdl/closest_point_on_segment_2d.sv =====
// an accepted input beat passes stages 1 to 5, the divider row and an output register to its result beat
// throughput: one beat per cycle; the quotient comes out of a row of
// COORD_WIDTH + 2 divider cells, one bit of both coordinates per cell
// a stall on the output holds the whole pipeline
// reset clears all valid flags and sets the clamp setting clamp_q to 1
module closest_point_on_segment_2d #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] line_start_x,
	input  logic signed [COORD_WIDTH-1:0] line_start_y,
	input  logic signed [COORD_WIDTH-1:0] line_end_x,
	input  logic signed [COORD_WIDTH-1:0] line_end_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] closest_x,
	output logic signed [COORD_WIDTH-1:0] closest_y,
	output logic [1:0]                    where_found,
	output logic                          saturated
);

	localparam int W    = COORD_WIDTH;
	localparam int PW   = 2*W + 2;
	localparam int DOTW = 2*W + 3;
	localparam int MW   = 3*W + 4;
	localparam int NSW  = 3*W + 5;
	localparam int NW   = 3*W + 4;
	localparam int DW   = 2*W + 3;
	localparam int QB   = W + 2;
	localparam int SIDE = 2*W + 4;
	localparam int RW   = W + 3;

	logic clamp_q;
	logic en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_q <= 1'b1;
		end else if (cfg_valid) begin
			clamp_q <= cfg_data;
		end
	end

	logic out_valid_q;
	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	// stage 1: differences
	logic v_s1, clamp_s1;
	logic signed [W:0]   dx_s1, dy_s1, ax_s1, ay_s1;
	logic signed [W-1:0] sx_s1, sy_s1, ex_s1, ey_s1, px_s1, py_s1;
	// stage 2: products
	logic v_s2, clamp_s2;
	logic signed [W:0]    dx_s2, dy_s2;
	logic signed [PW-1:0] ddx_s2, ddy_s2, pdx_s2, pdy_s2;
	logic signed [W-1:0]  sx_s2, sy_s2, ex_s2, ey_s2, px_s2, py_s2;
	// stage 3: squared length and dot
	logic v_s3, clamp_s3;
	logic signed [W:0]      dx_s3, dy_s3;
	logic signed [DOTW-1:0] len_s3, dot_s3;
	logic signed [W-1:0]    sx_s3, sy_s3, ex_s3, ey_s3, px_s3, py_s3;
	// stage 4: decision and scaled dot
	logic v_s4;
	cpseg_pkg::where_t      where_s4, where_c;
	logic signed [DOTW-1:0] len_s4;
	logic signed [MW-1:0]   mx_s4, my_s4;
	logic signed [W-1:0]    bx_s4, by_s4, bx_c, by_c;
	// stage 5: divider operands
	logic v_s5;
	logic [NW-1:0]   nx_s5, ny_s5;
	logic [DW-1:0]   d_s5;
	logic [SIDE-1:0] side_s5;

	always_comb begin
		if (clamp_s3 && dot_s3 > len_s3) begin
			where_c = cpseg_pkg::WHERE_END;
			bx_c    = ex_s3;
			by_c    = ey_s3;
		end else if (clamp_s3 && dot_s3 < 0) begin
			where_c = cpseg_pkg::WHERE_START;
			bx_c    = sx_s3;
			by_c    = sy_s3;
		end else if (len_s3 == '0) begin
			where_c = cpseg_pkg::WHERE_DEGEN;
			bx_c    = px_s3;
			by_c    = py_s3;
		end else begin
			where_c = cpseg_pkg::WHERE_PROJ;
			bx_c    = sx_s3;
			by_c    = sy_s3;
		end
	end

	// rounded quotient floor((2m + L) / 2L), negative numerators folded to magnitude
	logic signed [NSW-1:0] numx, numy, dm1;
	logic [DW-1:0]         d_c;
	logic                  negx, negy;

	always_comb begin
		d_c  = {len_s4[DW-2:0], 1'b0};
		dm1  = NSW'($signed({1'b0, d_c})) - NSW'(1);
		numx = (NSW'(mx_s4) <<< 1) + NSW'(len_s4);
		numy = (NSW'(my_s4) <<< 1) + NSW'(len_s4);
		negx = numx[NSW-1];
		negy = numy[NSW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clamp_s1 <= clamp_q;
			dx_s1    <= (W+1)'(line_end_x) - (W+1)'(line_start_x);
			dy_s1    <= (W+1)'(line_end_y) - (W+1)'(line_start_y);
			ax_s1    <= (W+1)'(point_x) - (W+1)'(line_start_x);
			ay_s1    <= (W+1)'(point_y) - (W+1)'(line_start_y);
			sx_s1    <= line_start_x;
			sy_s1    <= line_start_y;
			ex_s1    <= line_end_x;
			ey_s1    <= line_end_y;
			px_s1    <= point_x;
			py_s1    <= point_y;

			clamp_s2 <= clamp_s1;
			dx_s2    <= dx_s1;
			dy_s2    <= dy_s1;
			ddx_s2   <= PW'(dx_s1) * PW'(dx_s1);
			ddy_s2   <= PW'(dy_s1) * PW'(dy_s1);
			pdx_s2   <= PW'(ax_s1) * PW'(dx_s1);
			pdy_s2   <= PW'(ay_s1) * PW'(dy_s1);
			sx_s2    <= sx_s1;
			sy_s2    <= sy_s1;
			ex_s2    <= ex_s1;
			ey_s2    <= ey_s1;
			px_s2    <= px_s1;
			py_s2    <= py_s1;

			clamp_s3 <= clamp_s2;
			dx_s3    <= dx_s2;
			dy_s3    <= dy_s2;
			len_s3   <= DOTW'(ddx_s2) + DOTW'(ddy_s2);
			dot_s3   <= DOTW'(pdx_s2) + DOTW'(pdy_s2);
			sx_s3    <= sx_s2;
			sy_s3    <= sy_s2;
			ex_s3    <= ex_s2;
			ey_s3    <= ey_s2;
			px_s3    <= px_s2;
			py_s3    <= py_s2;

			where_s4 <= where_c;
			len_s4   <= len_s3;
			mx_s4    <= MW'(dx_s3) * MW'(dot_s3);
			my_s4    <= MW'(dy_s3) * MW'(dot_s3);
			bx_s4    <= bx_c;
			by_s4    <= by_c;

			nx_s5    <= negx ? NW'(dm1 - numx) : NW'(numx);
			ny_s5    <= negy ? NW'(dm1 - numy) : NW'(numy);
			d_s5     <= d_c;
			side_s5  <= {where_s4, negx, negy, bx_s4, by_s4};
		end
	end

	// divider row, most significant quotient bit first
	logic [QB:0]           v_ch;
	logic [QB:0][NW-1:0]   rx_ch, ry_ch;
	logic [QB:0][QB-1:0]   qx_ch, qy_ch;
	logic [QB:0][DW-1:0]   d_ch;
	logic [QB:0][SIDE-1:0] side_ch;

	assign v_ch[0]    = v_s5;
	assign rx_ch[0]   = nx_s5;
	assign ry_ch[0]   = ny_s5;
	assign qx_ch[0]   = '0;
	assign qy_ch[0]   = '0;
	assign d_ch[0]    = d_s5;
	assign side_ch[0] = side_s5;

	for (genvar k = 0; k < QB; k++) begin : g_cell
		cpseg_div_cell #(
			.NW(NW), .DW(DW), .QB(QB), .SIDE(SIDE), .SHIFT(QB-1-k)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.v_i(v_ch[k]), .rx_i(rx_ch[k]), .ry_i(ry_ch[k]),
			.qx_i(qx_ch[k]), .qy_i(qy_ch[k]), .d_i(d_ch[k]), .side_i(side_ch[k]),
			.v_o(v_ch[k+1]), .rx_o(rx_ch[k+1]), .ry_o(ry_ch[k+1]),
			.qx_o(qx_ch[k+1]), .qy_o(qy_ch[k+1]), .d_o(d_ch[k+1]),
			.side_o(side_ch[k+1])
		);
	end

	// finish: sign, add start point, saturate
	logic [1:0]          wf;
	logic                fnx, fny;
	logic signed [W-1:0] fbx, fby;
	logic signed [RW-1:0] qsx, qsy, sumx, sumy;
	logic signed [W-1:0] rx_c, ry_c;
	logic                clipx, clipy, is_proj;

	localparam logic signed [RW-1:0] CMAX = RW'((64'sd1 <<< (W-1)) - 64'sd1);
	localparam logic signed [RW-1:0] CMIN = -CMAX - RW'(1);

	always_comb begin
		{wf, fnx, fny, fbx, fby} = side_ch[QB];
		is_proj = wf == cpseg_pkg::WHERE_PROJ;
		qsx  = fnx ? -RW'(qx_ch[QB]) : RW'(qx_ch[QB]);
		qsy  = fny ? -RW'(qy_ch[QB]) : RW'(qy_ch[QB]);
		sumx = is_proj ? RW'(fbx) + qsx : RW'(fbx);
		sumy = is_proj ? RW'(fby) + qsy : RW'(fby);
		clipx = (sumx > CMAX) || (sumx < CMIN);
		clipy = (sumy > CMAX) || (sumy < CMIN);
		rx_c = (sumx > CMAX) ? W'(CMAX) : (sumx < CMIN) ? W'(CMIN) : W'(sumx);
		ry_c = (sumy > CMAX) ? W'(CMAX) : (sumy < CMIN) ? W'(CMIN) : W'(sumy);
	end

	logic signed [W-1:0] cx_q, cy_q;
	logic [1:0]          wf_q;
	logic                sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_ch[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_ch[QB]) begin
			cx_q  <= rx_c;
			cy_q  <= ry_c;
			wf_q  <= wf;
			sat_q <= clipx || clipy;
		end
	end

	assign out_valid   = out_valid_q;
	assign closest_x   = cx_q;
	assign closest_y   = cy_q;
	assign where_found = wf_q;
	assign saturated   = sat_q;

endmodule

// ===== bench/tb_closest_point_on_segment_2d.sv =====
module tb_closest_point_on_segment_2d;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 16;
	localparam int LATENCY = CW + 8;

	typedef struct {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		cpseg_pkg::where_t    where;
		logic                 sat;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CW-1:0] point_x = '0, point_y = '0;
	logic signed [CW-1:0] line_start_x = '0, line_start_y = '0;
	logic signed [CW-1:0] line_end_x = '0, line_end_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [CW-1:0] closest_x, closest_y;
	logic [1:0] where_found;
	logic saturated;

	answer_t pending_answers[$];
	logic clamp_mode;
	int mismatches = 0;
	int beats_sent = 0;
	int beats_checked = 0;
	int clamp_hits[4] = '{0, 0, 0, 0};

	always #2 clk = ~clk;

	closest_point_on_segment_2d #(.COORD_WIDTH(CW)) u_top (.*);

	function automatic longint round_nearest(longint num, longint den);
		longint a, b, q;
		a = 2 * num + den;
		b = 2 * den;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q--;
		return q;
	endfunction

	function automatic logic signed [CW-1:0] clip(longint v, ref logic flag);
		longint hi, lo;
		hi = (longint'(1) <<< (CW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			flag = 1'b1;
			return CW'(hi);
		end
		if (v < lo) begin
			flag = 1'b1;
			return CW'(lo);
		end
		return CW'(v);
	endfunction

	function automatic answer_t closest_point(longint px, longint py, longint sx,
			longint sy, longint ex, longint ey);
		answer_t a;
		longint dx, dy, len2, dotp, c1, c2;
		logic flag;
		dx = ex - sx;
		dy = ey - sy;
		len2 = dx * dx + dy * dy;
		dotp = (px - sx) * dx + (py - sy) * dy;
		flag = 1'b0;
		if (clamp_mode && dotp > len2) begin
			a.cx = CW'(ex); a.cy = CW'(ey); a.where = cpseg_pkg::WHERE_END;
		end else if (clamp_mode && dotp < 0) begin
			a.cx = CW'(sx); a.cy = CW'(sy); a.where = cpseg_pkg::WHERE_START;
		end else if (len2 == 0) begin
			a.cx = CW'(px); a.cy = CW'(py); a.where = cpseg_pkg::WHERE_DEGEN;
		end else begin
			c1 = dy * sx - dx * sy;
			c2 = dx * px + dy * py;
			a.cx = clip(round_nearest(dy * c1 + dx * c2, len2), flag);
			a.cy = clip(round_nearest(dy * c2 - dx * c1, len2), flag);
			a.where = cpseg_pkg::WHERE_PROJ;
		end
		a.sat = flag;
		return a;
	endfunction

	task automatic send_query(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
			logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
			logic signed [CW-1:0] ex, logic signed [CW-1:0] ey);
		int gap;
		gap = $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		// valid stays up straight into the next beat when there is no gap
		if (gap != 0 && in_valid)
			in_valid <= 1'b0;
		repeat (gap) @(posedge clk);
		in_valid <= 1'b1;
		point_x <= px; point_y <= py;
		line_start_x <= sx; line_start_y <= sy;
		line_end_x <= ex; line_end_y <= ey;
		do @(posedge clk); while (in_stall);
		pending_answers.push_back(closest_point(longint'(px), longint'(py),
			longint'(sx), longint'(sy), longint'(ex), longint'(ey)));
		beats_sent++;
	endtask

	task automatic drain_results();
		if (in_valid)
			in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_clamp(logic v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		clamp_mode = v;
	endtask

	// stall pattern, with quiet stretches
	initial begin
		int s;
		forever begin
			@(posedge clk);
			s = $urandom_range(0, 5);
			if ($urandom_range(0, 2) == 0)
				s = 0;
			if (s != 0) begin
				out_stall <= 1'b1;
				repeat (s) @(posedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		answer_t e;
		if (arst_n && out_valid && !out_stall) begin
			beats_checked++;
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %0d %0d", closest_x, closest_y);
			end else begin
				e = pending_answers.pop_front();
				clamp_hits[e.where]++;
				if (closest_x !== e.cx || closest_y !== e.cy ||
						where_found !== e.where || saturated !== e.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp (%0d,%0d) w%0d s%0b got (%0d,%0d) w%0d s%0b",
							e.cx, e.cy, e.where, e.sat,
							closest_x, closest_y, where_found, saturated);
				end
			end
		end
	end

	function automatic logic signed [CW-1:0] rnd_coord(int span);
		if (span >= 32768)
			return CW'($urandom);
		return CW'($urandom_range(0, 2 * span) - span);
	endfunction

	task automatic test_extremes();
		logic signed [CW-1:0] mx, mn;
		mx = 16'sh7fff;
		mn = 16'sh8000;
		send_query(mx, mx, mn, mn, mx, mx);
		send_query(mn, mx, mn, mn, mx, mx);
		send_query(mx, mn, mn, mx, mx, mn);
		send_query(mn, mn, mx, mx, mn, mn);
		send_query(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 16'sh1234, 16'shedcb);
	endtask

	task automatic test_clamp_cases();
		send_query(100, 0, 0, 0, 10, 0);      // beyond the end
		send_query(-50, 7, 0, 0, 10, 0);      // before the start
		send_query(0, 30, 0, 0, 10, 0);       // dot exactly zero
		send_query(10, -30, 0, 0, 10, 0);     // dot exactly the length
		send_query(5, 5, 0, 0, 10, 10);       // interior
		send_query(3, 4, 1, 2, 1, 2);         // zero-length line
		send_query(16'sh7fff, 16'sh8000, 7, 7, 7, 7);
		send_query(1, 2, -3, 0, 4, 9);        // projection that needs rounding
	endtask

	task automatic test_line_mode();
		send_query(16'sh7fff, 16'sh7fff, 0, 0, 1, 1);
		send_query(16'sh8000, 16'sh7fff, 16'sh7000, 0, 16'sh7fff, 1);
		send_query(100, 0, 0, 0, 10, 0);
		send_query(-50, 7, 0, 0, 10, 0);
		send_query(2, 2, 5, 5, 5, 5);
	endtask

	task automatic test_random(int count);
		int span;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 3))
				0: span = 32768;
				1: span = 2000;
				2: span = 64;
				default: span = 4;
			endcase
			if ($urandom_range(0, 15) == 0) begin
				logic signed [CW-1:0] sx, sy;
				sx = rnd_coord(span);
				sy = rnd_coord(span);
				send_query(rnd_coord(span), rnd_coord(span), sx, sy, sx, sy);
			end else
				send_query(rnd_coord(span), rnd_coord(span), rnd_coord(span),
					rnd_coord(span), rnd_coord(span), rnd_coord(span));
		end
	endtask

	task automatic test_drain_pause();
		send_query(1, 1, 0, 0, 4, 4);
		drain_results();
		send_query(-1, 9, 0, 0, 4, 4);
	endtask

	initial begin
		clamp_mode = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_clamp_cases();
		test_random(150);
		test_drain_pause();
		write_clamp(1'b0);
		test_line_mode();
		test_random(170);
		write_clamp(1'b1);
		test_clamp_cases();
		test_random(170);
		drain_results();
		$display("%0d beats sent, %0d checked; interior %0d end %0d start %0d degenerate %0d",
			beats_sent, beats_checked, clamp_hits[0], clamp_hits[1],
			clamp_hits[2], clamp_hits[3]);
		$display("both clamp settings covered, including saturation and zero-length lines");
		if (mismatches == 0 && pending_answers.size() == 0)
			$display("closest_point_on_segment_2d verification clean");
		else
			$display("closest_point_on_segment_2d verification failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("closest_point_on_segment_2d verification failed");
		$finish;
	end
endmodule

// ===== files.f =====
hdl/cpseg_pkg.sv
hdl/cpseg_div_cell.sv
hdl/closest_point_on_segment_2d.sv
bench/tb_closest_point_on_segment_2d.sv
